// ===== hdl/mbsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsm_pkg
// shared types and constants of the multi buffer swap manager
// ----------------------------------------------------------------------------
package mbsm_pkg;

    // fixed field widths of the item and result
    localparam int STAMP_BITS    = 48;
    localparam int SLOT_BITS     = 4;
    localparam int QUEUED_BITS   = 5;
    localparam int CFG_BITS      = 5;

    // default storage depth
    localparam int DEF_MAX_SLOTS = 16;

    // ring size floor and queued ceiling
    localparam int RING_MIN      = 3;
    localparam logic [QUEUED_BITS-1:0] QUEUED_MAX = '1;
    localparam logic [CFG_BITS-1:0]    CFG_RESET  = CFG_BITS'(RING_MIN);

    // operation codes
    localparam logic [1:0] OP_NEXT_READ  = 2'd0;
    localparam logic [1:0] OP_END_READ   = 2'd1;
    localparam logic [1:0] OP_NEXT_WRITE = 2'd2;
    localparam logic [1:0] OP_END_WRITE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_GRANTED    = 2'd0;
    localparam logic [1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [1:0] ST_RELEASED   = 2'd2;

    typedef struct packed {
        logic [1:0]            operation;
        logic [STAMP_BITS-1:0] stamp;
        logic                  stamp_given;
        logic [STAMP_BITS-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic [SLOT_BITS-1:0]   slot;
        logic [STAMP_BITS-1:0]  slot_stamp;
        logic [QUEUED_BITS-1:0] queued_count;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic exec;
        logic respond;
    } t_ctl_cmd;

endpackage

// ===== hdl/mbsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsm_ctrl
// sequencer: takes an item, runs one update step, then presents the result
// ----------------------------------------------------------------------------
module mbsm_ctrl
    import mbsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_ctl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.exec    = (r_state == S_IDLE) && start;
    assign o_cmd.respond = (r_state == S_RESP);

endmodule

// ===== hdl/mbsm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsm_datapath
// slot ring state, release and claim logic, stamp memory and result registers
// ----------------------------------------------------------------------------
module mbsm_datapath
    import mbsm_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl_cmd            i_cmd,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output t_out_item           o_result
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (RW > CFG_BITS) ? RW : CFG_BITS;
    localparam logic [CW-1:0] RING_LO = CW'(RING_MIN);
    localparam logic [CW-1:0] RING_HI = CW'(MAX_SLOTS);

    function automatic logic [IW-1:0] f_following(input logic [IW-1:0] idx,
                                                  input logic [CW-1:0] ring);
        logic [CW-1:0] nxt;
        nxt = CW'(idx) + CW'(1);
        return (nxt >= ring) ? '0 : nxt[IW-1:0];
    endfunction

    // configuration and control state
    logic [CFG_BITS-1:0]    r_cfg;
    logic [MAX_SLOTS-1:0]   r_flags, n_flags;
    logic [IW-1:0]          r_rd_slot, n_rd_slot;
    logic                   r_rd_started, n_rd_started;
    logic                   r_rd_active, n_rd_active;
    logic [IW-1:0]          r_wr_slot, n_wr_slot;
    logic                   r_wr_started, n_wr_started;
    logic                   r_wr_active, n_wr_active;
    logic [QUEUED_BITS-1:0] r_queued, n_queued;

    // stamp memory and result payload
    logic [STAMP_BITS-1:0]  r_mem [MAX_SLOTS];
    logic [STAMP_BITS-1:0]  r_rd_data;
    logic [STAMP_BITS-1:0]  r_wr_stamp;
    logic [1:0]             r_status, n_status;
    logic [IW-1:0]          r_slot, n_slot;
    logic                   r_from_mem, n_from_mem;

    logic [CW-1:0]          cfg_ext;
    logic [CW-1:0]          ring;
    logic [IW-1:0]          rd_cand;
    logic [IW-1:0]          wr_cand;
    logic                   rd_grant;
    logic                   wr_grant;
    logic [STAMP_BITS-1:0]  sel_stamp;

    assign cfg_ext = CW'(r_cfg);
    assign ring    = (cfg_ext < RING_LO) ? RING_LO :
                     (cfg_ext > RING_HI) ? RING_HI : cfg_ext;

    assign sel_stamp = i_item.stamp_given ? i_item.stamp : i_item.now_time;

    always_comb begin
        n_flags      = r_flags;
        n_rd_slot    = r_rd_slot;
        n_rd_started = r_rd_started;
        n_rd_active  = r_rd_active;
        n_wr_slot    = r_wr_slot;
        n_wr_started = r_wr_started;
        n_wr_active  = r_wr_active;
        n_queued     = r_queued;
        n_status     = ST_RELEASED;
        n_slot       = '0;
        n_from_mem   = 1'b0;
        rd_grant     = 1'b0;
        wr_grant     = 1'b0;

        // first writer slot follows the reader, or slot 0
        rd_cand = r_rd_started ? f_following(r_rd_slot, ring) : '0;
        wr_cand = r_wr_started ? f_following(r_wr_slot, ring) : rd_cand;

        unique case (i_item.operation)
            OP_NEXT_READ, OP_END_READ: begin
                if (r_rd_active) begin
                    n_flags[r_rd_slot] = 1'b0;
                    if (r_queued != '0) n_queued = r_queued - QUEUED_BITS'(1);
                end
                n_rd_active = 1'b0;
            end
            OP_NEXT_WRITE, OP_END_WRITE: begin
                if (r_wr_active) begin
                    n_flags[r_wr_slot] = 1'b1;
                    if (r_queued != QUEUED_MAX) n_queued = r_queued + QUEUED_BITS'(1);
                end
                n_wr_active = 1'b0;
            end
            default: ;
        endcase

        unique case (i_item.operation)
            OP_NEXT_READ: begin
                rd_grant = n_flags[rd_cand] && !(r_wr_active && r_wr_slot == rd_cand);
                if (rd_grant) begin
                    n_rd_slot    = rd_cand;
                    n_rd_started = 1'b1;
                    n_rd_active  = 1'b1;
                    n_status     = ST_GRANTED;
                    n_slot       = rd_cand;
                    n_from_mem   = 1'b1;
                end else begin
                    n_status = ST_NO_SLOT;
                end
            end
            OP_NEXT_WRITE: begin
                wr_grant = !n_flags[wr_cand] && !(r_rd_active && r_rd_slot == wr_cand);
                if (wr_grant) begin
                    n_wr_slot    = wr_cand;
                    n_wr_started = 1'b1;
                    n_wr_active  = 1'b1;
                    n_status     = ST_GRANTED;
                    n_slot       = wr_cand;
                end else begin
                    n_status = ST_NO_SLOT;
                end
            end
            OP_END_READ, OP_END_WRITE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= CFG_RESET;
            r_flags      <= '0;
            r_rd_slot    <= '0;
            r_rd_started <= 1'b0;
            r_rd_active  <= 1'b0;
            r_wr_slot    <= '0;
            r_wr_started <= 1'b0;
            r_wr_active  <= 1'b0;
            r_queued     <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (i_cmd.exec) begin
                r_flags      <= n_flags;
                r_rd_slot    <= n_rd_slot;
                r_rd_started <= n_rd_started;
                r_rd_active  <= n_rd_active;
                r_wr_slot    <= n_wr_slot;
                r_wr_started <= n_wr_started;
                r_wr_active  <= n_wr_active;
                r_queued     <= n_queued;
            end
        end
    end

    // stamp memory: at most one write and one registered read per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_grant) r_mem[wr_cand] <= sel_stamp;
        if (i_cmd.exec) r_rd_data <= r_mem[rd_cand];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_slot     <= n_slot;
            r_from_mem <= n_from_mem;
            r_wr_stamp <= sel_stamp;
        end
    end

    assign o_result.status       = r_status;
    assign o_result.slot         = SLOT_BITS'(r_slot);
    assign o_result.slot_stamp   = (r_status != ST_GRANTED) ? '0 :
                                   r_from_mem ? r_rd_data : r_wr_stamp;
    assign o_result.queued_count = r_queued;

endmodule

// ===== hdl/multi_buffer_swap_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_buffer_swap_manager
// ring of buffer slots handed between one writer and one reader
// ----------------------------------------------------------------------------
// o_done is high with the result in the cycle after the item is taken
// no new item is taken while a result is shown; the sequencer holds busy high
//   through the result cycle that the registered stamp memory read needs
// the receiver cannot stall: each result is shown for exactly one cycle
// reset (synchronous, active low): clears unread flags, slot indices, queued
//   count and sets the ring size to 3; stamp memory is not cleared
// ----------------------------------------------------------------------------
module multi_buffer_swap_manager
    import mbsm_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                start,
    output logic                busy,
    input  t_in_item            i_item,
    // result channel
    output logic                o_done,
    output t_out_item           o_result,
    // ring size register
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    // command bundle from the sequencer into the datapath
    t_ctl_cmd cmd;

    // sequencer: idle state, then the result state for each item
    mbsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // slot ring state; the whole release-and-claim step runs on the accept edge
    mbsm_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

    // result strobe comes straight from the sequencer state
    assign o_done = cmd.respond;

endmodule

// ===== verif/mbsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsm_checker
// predicts the slot ring results and compares every result field
// ----------------------------------------------------------------------------
module mbsm_checker
    import mbsm_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  t_in_item            i_item,
    input  logic                i_done,
    input  t_out_item           i_result,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // shadow state of the ring
    logic [MAX_SLOTS-1:0]   unread;
    logic [STAMP_BITS-1:0]  stamps [MAX_SLOTS];
    logic [SLOT_BITS-1:0]   rd_slot;
    logic [SLOT_BITS-1:0]   wr_slot;
    logic                   rd_started;
    logic                   rd_active;
    logic                   wr_started;
    logic                   wr_active;
    logic [QUEUED_BITS-1:0] queued;
    logic [CFG_BITS-1:0]    ring_cfg;

    t_out_item predicted_results [$];
    int        fails = 0;
    int        waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    // ring neighbor, clamped ring size, out-of-ring index wraps to slot 0
    function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] idx);
        int n;
        int nxt;
        n = int'(ring_cfg);
        if (n < RING_MIN) n = RING_MIN;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        nxt = int'(idx) + 1;
        return (nxt >= n) ? '0 : SLOT_BITS'(nxt);
    endfunction

    task automatic drop_reader();
        if (rd_active) begin
            unread[rd_slot] = 1'b0;
            if (queued != '0) queued = queued - QUEUED_BITS'(1);
        end
        rd_active = 1'b0;
    endtask

    task automatic drop_writer();
        if (wr_active) begin
            unread[wr_slot] = 1'b1;
            if (queued != QUEUED_MAX) queued = queued + QUEUED_BITS'(1);
        end
        wr_active = 1'b0;
    endtask

    task automatic serve_request(input t_in_item req, output t_out_item res);
        logic [SLOT_BITS-1:0] cand;
        res = '0;
        res.status = ST_RELEASED;
        case (req.operation)
            OP_NEXT_READ: begin
                drop_reader();
                cand = rd_started ? next_slot(rd_slot) : '0;
                if (unread[cand] && !(wr_active && wr_slot == cand)) begin
                    rd_slot        = cand;
                    rd_started     = 1'b1;
                    rd_active      = 1'b1;
                    res.status     = ST_GRANTED;
                    res.slot       = cand;
                    res.slot_stamp = stamps[cand];
                end else begin
                    res.status = ST_NO_SLOT;
                end
            end
            OP_END_READ: begin
                drop_reader();
            end
            OP_NEXT_WRITE: begin
                drop_writer();
                if (wr_started) cand = next_slot(wr_slot);
                else cand = rd_started ? next_slot(rd_slot) : '0;
                if (!unread[cand] && !(rd_active && rd_slot == cand)) begin
                    wr_slot        = cand;
                    wr_started     = 1'b1;
                    wr_active      = 1'b1;
                    stamps[cand]   = req.stamp_given ? req.stamp : req.now_time;
                    res.status     = ST_GRANTED;
                    res.slot       = cand;
                    res.slot_stamp = stamps[cand];
                end else begin
                    res.status = ST_NO_SLOT;
                end
            end
            default: begin
                drop_writer();
            end
        endcase
        res.queued_count = queued;
    endtask

    task automatic check_field(input string field_name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field_name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item predicted;
        if (!i_rst_n) begin
            unread     = '0;
            rd_slot    = '0;
            wr_slot    = '0;
            rd_started = 1'b0;
            rd_active  = 1'b0;
            wr_started = 1'b0;
            wr_active  = 1'b0;
            queued     = '0;
            ring_cfg   = CFG_RESET;
            for (int i = 0; i < MAX_SLOTS; i++) stamps[i] = '0;
            predicted_results.delete();
        end else begin
            if (i_cfg_we) ring_cfg = i_cfg_data;
            if (i_start && !i_busy) begin
                serve_request(i_item, predicted);
                predicted_results.push_back(predicted);
            end
            if (i_done) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %p",
                             $time, i_result);
                    fails++;
                end else begin
                    predicted = predicted_results.pop_front();
                    check_field("status", 64'(predicted.status), 64'(i_result.status));
                    check_field("slot", 64'(predicted.slot), 64'(i_result.slot));
                    check_field("slot_stamp", 64'(predicted.slot_stamp),
                                64'(i_result.slot_stamp));
                    check_field("queued_count", 64'(predicted.queued_count),
                                64'(i_result.queued_count));
                end
            end
        end
        waiting = predicted_results.size();
    end

endmodule

// ===== verif/multi_buffer_swap_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_buffer_swap_manager_tb
// drives read and write requests into the slot ring manager under several
// ring sizes and sender idle rates; a checker beside the block predicts and
// compares every result
// ----------------------------------------------------------------------------
module multi_buffer_swap_manager_tb;
    import mbsm_pkg::*;

    // cycles with no item accepted and no result before the run is declared hung
    localparam int WATCHDOG_LIMIT = 200;
    // items per random phase
    localparam int PHASE_ITEMS    = 200;
    localparam int PHASES         = 7;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    t_in_item            i_item     = '0;
    logic                i_cfg_we   = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_data = CFG_RESET;
    logic                busy;
    logic                o_done;
    t_out_item           o_result;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_cycles = 0;

    // ring size per random phase: clamped values 2, 31, 17 and 0 included
    int ring_plan [PHASES] = '{16, 2, 31, 5, 17, 3, 0};

    multi_buffer_swap_manager u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    mbsm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hang detector: any accepted item or result restarts the count
    initial begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("multi_buffer_swap_manager: mismatch");
        $finish;
    end

    function automatic t_in_item build_request(input logic [1:0] op,
                                               input logic [STAMP_BITS-1:0] stamp,
                                               input logic given,
                                               input logic [STAMP_BITS-1:0] now);
        t_in_item req;
        req.operation   = op;
        req.stamp       = stamp;
        req.stamp_given = given;
        req.now_time    = now;
        return req;
    endfunction

    // mostly full-width random stamps, now and then all zeros or all ones
    function automatic logic [STAMP_BITS-1:0] random_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return r[STAMP_BITS-1:0];
        endcase
    endfunction

    // mode 0 fills the ring, mode 1 drains it, anything else mixes both sides
    function automatic t_in_item random_request(input int mode);
        logic [1:0] op;
        int         roll;
        roll = $urandom_range(99);
        case (mode)
            0: begin
                if (roll < 70)      op = OP_NEXT_WRITE;
                else if (roll < 80) op = OP_END_WRITE;
                else if (roll < 95) op = OP_NEXT_READ;
                else                op = OP_END_READ;
            end
            1: begin
                if (roll < 70)      op = OP_NEXT_READ;
                else if (roll < 80) op = OP_END_READ;
                else if (roll < 95) op = OP_NEXT_WRITE;
                else                op = OP_END_WRITE;
            end
            default: begin
                if (roll < 40)      op = OP_NEXT_WRITE;
                else if (roll < 80) op = OP_NEXT_READ;
                else if (roll < 90) op = OP_END_WRITE;
                else                op = OP_END_READ;
            end
        endcase
        return build_request(op, random_stamp(), 1'(($urandom_range(1))), random_stamp());
    endfunction

    // present one item and hold it until the block takes it; start stays high
    // afterwards so back-to-back items never see a low pulse
    task automatic send_request(input t_in_item req);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = req;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending, wait for every outstanding result, then idle before returning
    task automatic wait_quiet();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // ring size is only changed while the block is idle
    task automatic write_ring_size(input logic [CFG_BITS-1:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    initial begin : stimulus
        int mode;
        // reset held from time zero, released at a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, ring of 3 after reset
        // read with nothing unread is refused, bare releases change nothing
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        send_request(build_request(OP_END_READ, '1, 1'b1, '1));
        send_request(build_request(OP_END_WRITE, '1, 1'b0, '1));
        // fill the ring: given stamp, current time, then given again
        send_request(build_request(OP_NEXT_WRITE, '1, 1'b1, '0));
        send_request(build_request(OP_NEXT_WRITE, '0, 1'b0, '1));
        send_request(build_request(OP_NEXT_WRITE, 48'h5555_5555_5555, 1'b1,
                                   48'hAAAA_AAAA_AAAA));
        // next slot still unread: writer refused, keeps its index
        send_request(build_request(OP_NEXT_WRITE, 48'h1234_5678_9ABC, 1'b1, '0));
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        // writer resumes after its refused index while the reader holds a slot
        send_request(build_request(OP_NEXT_WRITE, 48'hAAAA_AAAA_AAAA, 1'b1,
                                   48'h5555_5555_5555));
        // next slot is held by the reader: refused
        send_request(build_request(OP_NEXT_WRITE, '0, 1'b0, 48'h0F0F_0F0F_0F0F));
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        send_request(build_request(OP_END_READ, '0, 1'b0, '0));
        send_request(build_request(OP_END_WRITE, '0, 1'b0, '0));

        // register above the slot count acts as the full ring
        write_ring_size(5'd31);
        send_request(build_request(OP_NEXT_WRITE, '0, 1'b0, 48'hFFFF_0000_FFFF));
        send_request(build_request(OP_NEXT_WRITE, 48'h0000_FFFF_0000, 1'b1, '0));
        send_request(build_request(OP_NEXT_WRITE, random_stamp(), 1'b1, random_stamp()));
        send_request(build_request(OP_NEXT_WRITE, random_stamp(), 1'b0, random_stamp()));

        // register of zero acts as 3: writer index now beyond the ring wraps to 0
        write_ring_size(5'd0);
        send_request(build_request(OP_NEXT_WRITE, random_stamp(), 1'b1, random_stamp()));
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        send_request(build_request(OP_NEXT_READ, '0, 1'b0, '0));
        send_request(build_request(OP_NEXT_WRITE, random_stamp(), 1'b0, random_stamp()));

        // random phases: sender idles 20 percent, then 56, then never
        for (int phase = 0; phase < PHASES; phase++) begin
            write_ring_size(ring_plan[phase][CFG_BITS-1:0]);
            if (phase < 3)      idle_pct = 20;
            else if (phase < 5) idle_pct = 56;
            else                idle_pct = 0;
            mode = 2;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // switch between fill, drain and mixed bursts
                if (n % 16 == 0) mode = $urandom_range(2);
                // occasional full drain of outstanding results
                if ($urandom_range(99) == 0) wait_quiet();
                send_request(random_request(mode));
            end
        end

        wait_quiet();
        if (fail_count == 0) begin
            $display("multi_buffer_swap_manager: match");
        end else begin
            $display("multi_buffer_swap_manager: mismatch");
        end
        $finish;
    end

endmodule
